/* rtl/core/rllr_pkg.sv */
package rllr_pkg;

	localparam int unsigned MAX_POINTS_DEF = 64;
	localparam logic [9:0]  PASS_RESET     = 10'd200;

	// Datapath commands issued by the controller.
	localparam logic [3:0] OP_NONE    = 4'd0;
	localparam logic [3:0] OP_LOAD    = 4'd1;
	localparam logic [3:0] OP_CAP_P0  = 4'd2;
	localparam logic [3:0] OP_CAP_P1  = 4'd3;
	localparam logic [3:0] OP_DIFF    = 4'd4;
	localparam logic [3:0] OP_SQ      = 4'd5;
	localparam logic [3:0] OP_ROOT    = 4'd6;
	localparam logic [3:0] OP_ERR     = 4'd7;
	localparam logic [3:0] OP_DIV     = 4'd8;
	localparam logic [3:0] OP_MUL_LO  = 4'd9;
	localparam logic [3:0] OP_MUL_HI  = 4'd10;
	localparam logic [3:0] OP_WB_LINK = 4'd11;
	localparam logic [3:0] OP_WB_LAST = 4'd12;
	localparam logic [3:0] OP_OUT     = 4'd13;

	localparam logic [1:0] AXIS_ACC = 2'd3;

	typedef struct packed {
		logic [3:0] op;
		logic [1:0] axis;
		logic       rd_en;
		logic       last;
	} rllr_cmd_t;

	typedef struct packed {
		logic root_done;
		logic div_done;
		logic out_free;
	} rllr_stat_t;

	function automatic logic [31:0] sat32(input logic signed [36:0] v);
		logic [31:0] r;
		if (v > 37'sh007FFFFFFF)
			r = 32'h7FFF_FFFF;
		else if (v < 37'sh1F80000000)
			r = 32'h8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

/* rtl/core/rllr_isqrt.sv */
module rllr_isqrt import rllr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic        done,
	output logic [31:0] root
);

	logic        run_q, done_q;
	logic [63:0] v_q, r_q, b_q;
	logic [63:0] trial;
	logic        ge;

	assign trial = r_q + b_q;
	assign ge    = v_q >= trial;
	assign done  = done_q;
	assign root  = r_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q & b_q[0];
			if (start)
				run_q <= 1'b1;
			else if (run_q && b_q[0])
				run_q <= 1'b0;
		end
	end

	// One result bit per cycle, the trial bit walking down two places at a time.
	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= radicand;
			r_q <= '0;
			b_q <= 64'h4000_0000_0000_0000;
		end else if (run_q) begin
			if (ge) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + b_q;
			end else begin
				r_q <= r_q >> 1;
			end
			b_q <= b_q >> 2;
		end
	end

endmodule

/* rtl/core/rllr_div.sv */
module rllr_div import rllr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [61:0] dividend,
	input  logic [32:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);

	logic        run_q, done_q;
	logic [4:0]  cnt_q;
	logic [32:0] rem_q;
	logic [31:0] low_q, q_q;
	logic [33:0] trial, diff;
	logic        ge;

	assign trial    = {rem_q, low_q[31]};
	assign diff     = trial - {1'b0, divisor};
	assign ge       = trial >= {1'b0, divisor};
	assign done     = done_q;
	assign quotient = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == 5'd31);
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31)
					run_q <= 1'b0;
			end
		end
	end

	// The quotient is known to fit 32 bits, so the upper dividend bits seed the remainder.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {3'b000, dividend[61:32]};
			low_q <= dividend[31:0];
			q_q   <= '0;
		end else if (run_q) begin
			rem_q <= ge ? diff[32:0] : trial[32:0];
			q_q   <= {q_q[30:0], ge};
			low_q <= {low_q[30:0], 1'b0};
		end
	end

endmodule

/* rtl/core/rllr_datapath.sv */
module rllr_datapath import rllr_pkg::*; #(
	parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
	localparam int unsigned AW = $clog2(MAX_POINTS)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rllr_cmd_t          cmd,
	input  logic [AW-1:0]      addr,
	output rllr_stat_t         stat,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic               pinned,
	input  logic [30:0]        rest_len,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic               last_out
);

	logic [31:0] mem_x [MAX_POINTS];
	logic [31:0] mem_y [MAX_POINTS];
	logic [31:0] mem_z [MAX_POINTS];
	logic        mem_pin [MAX_POINTS];
	logic [30:0] mem_rest [MAX_POINTS];

	logic [2:0][31:0] rd_q, p0_q, p1_q, wdata;
	logic             rd_pin_q, p0_pin_q, p1_pin_q;
	logic [30:0]      rd_rest_q, p0_rest_q;
	logic [2:0][34:0] carry_q, mv_q;
	logic [2:0][32:0] d_q, diff_c;
	logic [2:0][31:0] mag_q, mag_c;
	logic             big_q, skip_q;
	logic [63:0]      prod_q, sum_q;
	logic [32:0]      dist_q, dist_c;
	logic [34:0]      err_q, err_c, err_mag;
	logic             out_valid_q;

	logic [1:0]  axis_idx;
	logic [31:0] sq_op, mul_a, mul_b, root, quot;
	logic [63:0] mul_c, full_c;
	logic [33:0] hp_c, m_c;
	logic [34:0] mv_c;
	logic        neg_c, mem_wr, add_mv, root_done, div_done;

	assign axis_idx = (cmd.axis == AXIS_ACC) ? 2'd0 : cmd.axis;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			diff_c[k] = {p0_q[k][31], p0_q[k]} - {p1_q[k][31], p1_q[k]};
			mag_c[k]  = diff_c[k][32] ? 32'(-diff_c[k]) : diff_c[k][31:0];
		end
	end

	// Squares use halved magnitudes when any axis reaches 2^31.
	assign sq_op   = big_q ? {1'b0, mag_q[axis_idx][31:1]} : mag_q[axis_idx];
	assign err_mag = err_q[34] ? -err_q : err_q;
	assign mul_a   = (cmd.op == OP_MUL_LO) ? err_mag[31:0] : sq_op;
	assign mul_b   = (cmd.op == OP_MUL_LO) ? quot : sq_op;
	assign mul_c   = mul_a * mul_b;

	assign dist_c = big_q ? {root, 1'b0} : {1'b0, root};
	assign err_c  = $signed({4'b0000, p0_rest_q}) - $signed({2'b00, dist_c});

	assign hp_c   = err_mag[33:32] * quot;
	assign full_c = prod_q + {hp_c[31:0], 32'h0};
	assign m_c    = (!p0_pin_q && !p1_pin_q) ? {1'b0, full_c[63:31]} : full_c[63:30];
	assign neg_c  = d_q[axis_idx][32] ^ err_q[34];
	assign mv_c   = (skip_q || m_c == '0) ? '0 :
	                neg_c ? -{1'b0, m_c} : {1'b0, m_c};

	assign add_mv = (cmd.op == OP_WB_LINK) && !p0_pin_q;
	assign mem_wr = cmd.op inside {OP_LOAD, OP_WB_LINK, OP_WB_LAST};

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			wdata[k] = sat32($signed({{5{p0_q[k][31]}}, p0_q[k]})
			               + $signed({{2{carry_q[k][34]}}, carry_q[k]})
			               + (add_mv ? $signed({{2{mv_q[k][34]}}, mv_q[k]}) : 37'sd0));
		end
		if (cmd.op == OP_LOAD) begin
			wdata[0] = pos_x;
			wdata[1] = pos_y;
			wdata[2] = pos_z;
		end
	end

	rllr_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.op == OP_ROOT),
		.radicand (sum_q),
		.done     (root_done),
		.root     (root)
	);

	rllr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.op == OP_DIV),
		.dividend ({mag_q[axis_idx], 30'h0}),
		.divisor  (dist_q),
		.done     (div_done),
		.quotient (quot)
	);

	always_ff @(posedge clk) begin
		if (mem_wr) begin
			mem_x[addr] <= wdata[0];
			mem_y[addr] <= wdata[1];
			mem_z[addr] <= wdata[2];
		end
		if (cmd.op == OP_LOAD) begin
			mem_pin[addr]  <= pinned;
			mem_rest[addr] <= rest_len;
		end
		if (cmd.rd_en) begin
			rd_q[0]   <= mem_x[addr];
			rd_q[1]   <= mem_y[addr];
			rd_q[2]   <= mem_z[addr];
			rd_pin_q  <= mem_pin[addr];
			rd_rest_q <= mem_rest[addr];
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_CAP_P0: begin
				p0_q      <= rd_q;
				p0_pin_q  <= rd_pin_q;
				p0_rest_q <= rd_rest_q;
				carry_q   <= '0;
			end
			OP_CAP_P1: begin
				p1_q     <= rd_q;
				p1_pin_q <= rd_pin_q;
			end
			OP_DIFF: begin
				d_q    <= diff_c;
				mag_q  <= mag_c;
				big_q  <= mag_c[0][31] | mag_c[1][31] | mag_c[2][31];
				skip_q <= p0_pin_q & p1_pin_q;
			end
			OP_SQ: begin
				if (cmd.axis != AXIS_ACC)
					prod_q <= mul_c;
				if (cmd.axis == 2'd1)
					sum_q <= prod_q;
				else if (cmd.axis != 2'd0)
					sum_q <= sum_q + prod_q;
			end
			OP_ERR: begin
				dist_q <= dist_c;
				err_q  <= err_c;
				if (dist_c == '0)
					skip_q <= 1'b1;
			end
			OP_MUL_LO: prod_q <= mul_c;
			OP_MUL_HI: mv_q[axis_idx] <= mv_c;
			OP_WB_LINK: begin
				// The old snapshot of the far end becomes the near end of the next link.
				for (int k = 0; k < 3; k++)
					carry_q[k] <= p1_pin_q ? 35'd0 : -mv_q[k];
				p0_q      <= p1_q;
				p0_pin_q  <= p1_pin_q;
				p0_rest_q <= rd_rest_q;
			end
			OP_OUT: begin
				out_x    <= rd_q[0];
				out_y    <= rd_q[1];
				out_z    <= rd_q[2];
				last_out <= cmd.last;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.op == OP_OUT)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	assign out_valid      = out_valid_q;
	assign stat.root_done = root_done;
	assign stat.div_done  = div_done;
	assign stat.out_free  = !out_valid_q || !out_stall;

endmodule

/* rtl/core/rllr_ctrl.sv */
module rllr_ctrl import rllr_pkg::*; #(
	parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
	localparam int unsigned AW = $clog2(MAX_POINTS),
	localparam int unsigned CW = $clog2(MAX_POINTS + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          last_in,
	input  logic          cfg_wr_en,
	input  logic [9:0]    cfg_wr_data,
	input  rllr_stat_t    stat,
	output rllr_cmd_t     cmd,
	output logic [AW-1:0] addr
);

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_P_RD    = 5'd1;
	localparam logic [4:0] S_P_CAP   = 5'd2;
	localparam logic [4:0] S_L_RD    = 5'd3;
	localparam logic [4:0] S_L_CAP   = 5'd4;
	localparam logic [4:0] S_DIFF    = 5'd5;
	localparam logic [4:0] S_SQ      = 5'd6;
	localparam logic [4:0] S_ROOT    = 5'd7;
	localparam logic [4:0] S_ROOT_W  = 5'd8;
	localparam logic [4:0] S_ERR     = 5'd9;
	localparam logic [4:0] S_DIV     = 5'd10;
	localparam logic [4:0] S_DIV_W   = 5'd11;
	localparam logic [4:0] S_MLO     = 5'd12;
	localparam logic [4:0] S_MHI     = 5'd13;
	localparam logic [4:0] S_WB      = 5'd14;
	localparam logic [4:0] S_WL      = 5'd15;
	localparam logic [4:0] S_EMIT_RD = 5'd16;
	localparam logic [4:0] S_EMIT_W  = 5'd17;

	logic [4:0]    state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d, n_q, n_d;
	logic [AW-1:0] i_q, i_d, j_q, j_d;
	logic [9:0]    pass_q, pass_d, pass_count_q;
	logic [1:0]    axis_q, axis_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		n_d     = n_q;
		i_d     = i_q;
		j_d     = j_q;
		pass_d  = pass_q;
		axis_d  = axis_q;
		cmd     = '0;
		addr    = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					// Points beyond the store are dropped, but a last mark still counts.
					if (cnt_q < CW'(MAX_POINTS)) begin
						cmd.op = OP_LOAD;
						addr   = cnt_q[AW-1:0];
						cnt_d  = cnt_q + CW'(1);
					end
					if (last_in) begin
						n_d    = cnt_d;
						pass_d = '0;
						j_d    = '0;
						if (pass_count_q == '0 || n_d == CW'(1))
							state_d = S_EMIT_RD;
						else
							state_d = S_P_RD;
					end
				end
			end
			S_P_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_P_CAP;
			end
			S_P_CAP: begin
				cmd.op  = OP_CAP_P0;
				i_d     = '0;
				state_d = S_L_RD;
			end
			S_L_RD: begin
				cmd.rd_en = 1'b1;
				addr      = i_q + AW'(1);
				state_d   = S_L_CAP;
			end
			S_L_CAP: begin
				cmd.op  = OP_CAP_P1;
				state_d = S_DIFF;
			end
			S_DIFF: begin
				cmd.op  = OP_DIFF;
				axis_d  = '0;
				state_d = S_SQ;
			end
			S_SQ: begin
				cmd.op   = OP_SQ;
				cmd.axis = axis_q;
				axis_d   = axis_q + 2'd1;
				if (axis_q == AXIS_ACC)
					state_d = S_ROOT;
			end
			S_ROOT: begin
				cmd.op  = OP_ROOT;
				state_d = S_ROOT_W;
			end
			S_ROOT_W: begin
				if (stat.root_done)
					state_d = S_ERR;
			end
			S_ERR: begin
				cmd.op  = OP_ERR;
				axis_d  = '0;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.op   = OP_DIV;
				cmd.axis = axis_q;
				state_d  = S_DIV_W;
			end
			S_DIV_W: begin
				if (stat.div_done)
					state_d = S_MLO;
			end
			S_MLO: begin
				cmd.op   = OP_MUL_LO;
				cmd.axis = axis_q;
				state_d  = S_MHI;
			end
			S_MHI: begin
				cmd.op   = OP_MUL_HI;
				cmd.axis = axis_q;
				if (axis_q == 2'd2) begin
					axis_d  = '0;
					state_d = S_WB;
				end else begin
					axis_d  = axis_q + 2'd1;
					state_d = S_DIV;
				end
			end
			S_WB: begin
				cmd.op = OP_WB_LINK;
				addr   = i_q;
				i_d    = i_q + AW'(1);
				if (CW'(i_q) + CW'(2) == n_q)
					state_d = S_WL;
				else
					state_d = S_L_RD;
			end
			S_WL: begin
				cmd.op = OP_WB_LAST;
				addr   = AW'(n_q - CW'(1));
				pass_d = pass_q + 10'd1;
				if (pass_q + 10'd1 == pass_count_q) begin
					j_d     = '0;
					state_d = S_EMIT_RD;
				end else begin
					state_d = S_P_RD;
				end
			end
			S_EMIT_RD: begin
				cmd.rd_en = 1'b1;
				addr      = j_q;
				state_d   = S_EMIT_W;
			end
			S_EMIT_W: begin
				if (stat.out_free) begin
					cmd.op   = OP_OUT;
					cmd.last = (CW'(j_q) + CW'(1) == n_q);
					if (cmd.last) begin
						cnt_d   = '0;
						state_d = S_IDLE;
					end else begin
						j_d     = j_q + AW'(1);
						state_d = S_EMIT_RD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			n_q          <= '0;
			i_q          <= '0;
			j_q          <= '0;
			pass_q       <= '0;
			axis_q       <= '0;
			pass_count_q <= PASS_RESET;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			n_q     <= n_d;
			i_q     <= i_d;
			j_q     <= j_d;
			pass_q  <= pass_d;
			axis_q  <= axis_d;
			if (cfg_wr_en)
				pass_count_q <= cfg_wr_data;
		end
	end

endmodule

/* rtl/core/rope_link_length_relaxation_core.sv */
// Channel | Handshake            | Word
// input   | in_valid / in_stall  | pos_x, pos_y, pos_z, pinned, rest_len, last_in
// output  | out_valid / out_stall| out_x, out_y, out_z, last_out
// config  | cfg_wr_en            | cfg_wr_data (relaxation pass count)
//
// A point is written straight into the point store. The word marked last starts the relaxation
// (skipped when the pass count is zero or the rope holds one point): each link of each pass
// runs the bit-serial square root and three bit-serial divisions with their multiplies; one
// 32 by 32 multiplier serves squares and moves. After the passes, the points are emitted in
// order. Reset clears the controller and restores 200 passes; the point store is not cleared.
// Output stalls hold the emit sequence; no input is taken from the last word until the final
// point has gone into the output register.
module rope_link_length_relaxation_core import rllr_pkg::*; #(
	parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [9:0]         cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic               pinned,
	input  logic [30:0]        rest_len,
	input  logic               last_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic               last_out
);

	localparam int unsigned AW = $clog2(MAX_POINTS);

	rllr_cmd_t     cmd;
	rllr_stat_t    stat;
	logic [AW-1:0] addr;

	rllr_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.last_in     (last_in),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.stat        (stat),
		.cmd         (cmd),
		.addr        (addr)
	);

	rllr_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.addr      (addr),
		.stat      (stat),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.pinned    (pinned),
		.rest_len  (rest_len),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_z     (out_z),
		.last_out  (last_out)
	);

endmodule

/* rtl/core/rllr_checker.sv */
module rllr_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               last_in,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] out_x,
	input logic signed [31:0] out_y,
	input logic signed [31:0] out_z,
	input logic               last_out
);

	// A stalled output word stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y)
			&& $stable(out_z) && $stable(last_out))
		else $error("output word changed while stalled");

	// The last point of a rope ends loading, so input is held off.
	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_in |=> in_stall)
		else $error("input taken after the last point");

	// Loading continues straight on after an ordinary point.
	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !last_in |=> !in_stall)
		else $error("input stalled in the middle of loading");

	// While a word other than the final one is waiting, the rope is still being emitted.
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_out |-> in_stall)
		else $error("input ready before the rope was fully emitted");

endmodule

bind rope_link_length_relaxation_core rllr_checker u_rllr_checker (.*);
